### design/subtractive_random_generator_unit_assert.svh
// Assertion macros for the subtractive random generator.
// Included by the top level; no other dependencies.
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_UNIT_ASSERT_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SRG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srg: same-cycle check failed");
`define SRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srg: next-cycle check failed");
`else
`define SRG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SRG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/srg_pkg.sv
// Types, codes and constants shared by the subtractive random generator.
// No dependencies.
package srg_pkg;

	localparam int LAG_DEPTH   = 55;
	localparam int PTR_WRAP    = 56;
	localparam int SCATTER     = 21;
	localparam int TRAIL_START = 31;
	localparam int WARM_OFFSET = 30;
	localparam int WARM_PASSES = 4;
	localparam int IDX_W       = 6;
	localparam int WORD_W      = 30;
	localparam int PASS_W      = 2;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [PASS_W-1:0] pass_t;

	localparam idx_t LAST_IDX       = idx_t'(LAG_DEPTH - 1);
	localparam idx_t FIRST_FILL_IDX = idx_t'(SCATTER - 1);
	localparam idx_t SCATTER_STEP   = idx_t'(SCATTER);
	localparam idx_t DEPTH_IDX      = idx_t'(LAG_DEPTH);
	localparam idx_t TRAIL_INIT     = idx_t'(TRAIL_START);
	localparam idx_t WARM_B_START   = idx_t'((1 + WARM_OFFSET) % LAG_DEPTH);
	localparam pass_t LAST_PASS     = pass_t'(WARM_PASSES - 1);

	typedef enum logic {
		CMD_SEED = 1'b0,
		CMD_DRAW = 1'b1
	} srg_cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_SEED_BIG  = 2'd1,
		STAT_SEED_ZERO = 2'd2
	} srg_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW_WR,
		ST_FILL,
		ST_WARM_RD,
		ST_WARM_WR,
		ST_REPLY
	} srg_state_t;

	typedef struct packed {
		srg_cmd_t cmd;
		word_t    seed_value;
	} srg_in_t;

	typedef struct packed {
		word_t       random_value;
		srg_status_t status;
	} srg_out_t;

	// pointer step: 1..55, anything that runs past wraps to 1
	function automatic idx_t ptr_advance(idx_t p);
		idx_t n;
		n = p + idx_t'(1);
		if (n >= idx_t'(PTR_WRAP) || n == '0)
			n = idx_t'(1);
		return n;
	endfunction

	// slots are numbered from 1; stray slots fold onto entry 0
	function automatic idx_t slot_index(idx_t s);
		idx_t r;
		if (s == '0 || s > DEPTH_IDX)
			r = '0;
		else
			r = s - idx_t'(1);
		return r;
	endfunction

endpackage

### design/subtractive_random_generator_unit.sv
// Subtractive (lagged difference) random generator. A 55-word lag table sits
// in a memory with two registered read ports and one write port. A draw beat
// reads the lead and trail words on accept, then, once the output register is
// free, subtracts modulo MODULUS, writes back and loads that register. A valid
// seed goes through the seed write on accept, 54 fill writes, four warm-up
// passes of 55 read/write pairs on the same memory, then the reply. A rejected
// seed (zero, or not below MODULUS) goes straight to the reply and leaves the
// table alone. A new beat is taken while the last result still waits in the
// output register. Table entries read as zero until first written.
// Depends on srg_pkg and subtractive_random_generator_unit_assert.svh.
`include "subtractive_random_generator_unit_assert.svh"

module subtractive_random_generator_unit #(
	parameter int unsigned MODULUS = 1000000000
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  srg_pkg::srg_in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output srg_pkg::srg_out_t out_data
);
	import srg_pkg::*;

	localparam logic [WORD_W:0] MOD_W = (WORD_W+1)'(MODULUS);

	function automatic word_t sub_mod(word_t a, word_t b);
		logic [WORD_W:0] r;
		if (a >= b)
			r = {1'b0, a} - {1'b0, b};
		else
			r = {1'b0, a} + MOD_W - {1'b0, b};
		return r[WORD_W-1:0];
	endfunction

	srg_state_t state_q, state_d;

	word_t lag_mem [LAG_DEPTH];
	logic [LAG_DEPTH-1:0] vld_q;
	word_t rd_a_q, rd_b_q;
	logic  rd_a_vld_q, rd_b_vld_q;
	word_t rd_a, rd_b;

	idx_t  lead_q, trail_q;
	idx_t  lead_adv, trail_adv;
	idx_t  ctr_q, slot_q, b_q;
	pass_t pass_q;
	word_t cur_q, last_q, seed_q;
	srg_status_t status_q, status_c;
	logic  seed_ok;
	logic [IDX_W:0] slot_sum;

	logic  we_c, re_c;
	idx_t  wa_c, ra_c, rb_c;
	word_t wd_c;

	logic     out_valid_q, out_free, out_load;
	srg_out_t out_data_q, out_d;
	logic     accept;
	logic     draw_fire, draw_accept, warm_busy;

	assign lead_adv  = ptr_advance(lead_q);
	assign trail_adv = ptr_advance(trail_q);
	assign rd_a      = rd_a_vld_q ? rd_a_q : '0;
	assign rd_b      = rd_b_vld_q ? rd_b_q : '0;
	assign out_free  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign slot_sum  = {1'b0, slot_q} + {1'b0, SCATTER_STEP};

	assign draw_fire   = (state_q == ST_DRAW_WR) && out_free;
	assign draw_accept = accept && (in_data.cmd == CMD_DRAW);
	assign warm_busy   = (state_q == ST_WARM_RD) || (state_q == ST_WARM_WR);

	always_comb begin
		if ({1'b0, in_data.seed_value} >= MOD_W)
			status_c = STAT_SEED_BIG;
		else if (in_data.seed_value == '0)
			status_c = STAT_SEED_ZERO;
		else
			status_c = STAT_OK;
	end
	assign seed_ok = (status_c == STAT_OK);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		we_c     = 1'b0;
		wa_c     = '0;
		wd_c     = '0;
		re_c     = 1'b0;
		ra_c     = '0;
		rb_c     = '0;
		out_load = 1'b0;
		out_d    = '{random_value: '0, status: STAT_OK};
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_data.cmd == CMD_DRAW) begin
						re_c    = 1'b1;
						ra_c    = slot_index(lead_adv);
						rb_c    = slot_index(trail_adv);
						state_d = ST_DRAW_WR;
					end else if (seed_ok) begin
						we_c    = 1'b1;
						wa_c    = LAST_IDX;
						wd_c    = in_data.seed_value;
						state_d = ST_FILL;
					end else begin
						state_d = ST_REPLY;
					end
				end
			end
			ST_DRAW_WR: begin
				if (out_free) begin
					we_c     = 1'b1;
					wa_c     = slot_index(lead_q);
					wd_c     = sub_mod(rd_a, rd_b);
					out_load = 1'b1;
					out_d    = '{random_value: wd_c, status: STAT_OK};
					state_d  = ST_IDLE;
				end
			end
			ST_FILL: begin
				we_c = 1'b1;
				wa_c = slot_q;
				wd_c = cur_q;
				if (ctr_q == LAST_IDX)
					state_d = ST_WARM_RD;
			end
			ST_WARM_RD: begin
				re_c    = 1'b1;
				ra_c    = ctr_q;
				rb_c    = b_q;
				state_d = ST_WARM_WR;
			end
			ST_WARM_WR: begin
				we_c = 1'b1;
				wa_c = ctr_q;
				wd_c = sub_mod(rd_a, rd_b);
				if (ctr_q == LAST_IDX && pass_q == LAST_PASS)
					state_d = ST_REPLY;
				else
					state_d = ST_WARM_RD;
			end
			ST_REPLY: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{random_value: seed_q, status: status_q};
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// lag table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we_c)
			lag_mem[wa_c] <= wd_c;
		if (re_c) begin
			rd_a_q <= lag_mem[ra_c];
			rd_b_q <= lag_mem[rb_c];
		end
	end

	// per-entry written flags stand in for the all-zero reset table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
		end else begin
			if (we_c)
				vld_q[wa_c] <= 1'b1;
			if (re_c) begin
				rd_a_vld_q <= vld_q[ra_c];
				rd_b_vld_q <= vld_q[rb_c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q  <= '0;
			trail_q <= '0;
			ctr_q   <= '0;
			pass_q  <= '0;
		end else begin
			if (accept && in_data.cmd == CMD_DRAW) begin
				lead_q  <= lead_adv;
				trail_q <= trail_adv;
			end else if (accept && seed_ok) begin
				lead_q  <= '0;
				trail_q <= TRAIL_INIT;
				ctr_q   <= idx_t'(1);
			end else if (state_q == ST_FILL) begin
				ctr_q  <= (ctr_q == LAST_IDX) ? '0 : ctr_q + idx_t'(1);
				pass_q <= '0;
			end else if (state_q == ST_WARM_WR) begin
				if (ctr_q == LAST_IDX) begin
					ctr_q  <= '0;
					pass_q <= pass_q + pass_t'(1);
				end else begin
					ctr_q <= ctr_q + idx_t'(1);
				end
			end
		end
	end

	// fill and warm-up datapath
	always_ff @(posedge clk) begin
		if (accept && in_data.cmd == CMD_SEED) begin
			seed_q   <= in_data.seed_value;
			status_q <= status_c;
			slot_q   <= FIRST_FILL_IDX;
			cur_q    <= word_t'(1);
			last_q   <= in_data.seed_value;
		end else if (state_q == ST_FILL) begin
			cur_q  <= sub_mod(last_q, cur_q);
			last_q <= cur_q;
			slot_q <= (slot_sum >= {1'b0, DEPTH_IDX}) ?
				idx_t'(slot_sum - {1'b0, DEPTH_IDX}) : idx_t'(slot_sum);
			b_q    <= WARM_B_START;
		end else if (state_q == ST_WARM_WR) begin
			if (ctr_q == LAST_IDX)
				b_q <= WARM_B_START;
			else
				b_q <= (b_q == LAST_IDX) ? '0 : b_q + idx_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_data_q <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`SRG_ASSERT_SAME(a_wr_below_mod, clk, arst_n, we_c, (WORD_W+1)'(wd_c) < MOD_W)
	`SRG_ASSERT_NEXT(a_draw_result, clk, arst_n, draw_fire, out_valid && out_data.status == STAT_OK)
	`SRG_ASSERT_SAME(a_warm_index, clk, arst_n, warm_busy, ctr_q <= LAST_IDX)
	`SRG_ASSERT_NEXT(a_draw_ptrs, clk, arst_n, draw_accept, lead_q != '0 && trail_q != '0)

endmodule
